// ===== sv/ssg_pkg.sv =====
`default_nettype none
package ssg_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_FRAC_BITS = 30;

  localparam int QUAD_BITS = PHASE_BITS - 2;
  localparam int FOLD_BITS = PHASE_BITS - 1;

  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int PROD_W  = 128;
  localparam int Q_BITS  = 60;
  localparam int AMP_FRAC_BITS = 16;

  localparam int TUNE_W      = 32;
  localparam int AMP_W       = 17;
  localparam int SAMPLE_W    = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int TERMS      = 11;
  localparam int TERM_CNT_W = $clog2(TERMS + 1);
  localparam int DIV_W      = 9;

  localparam int ANGLE_SHIFT = 63;
  localparam int AMP_SHIFT   = Q_BITS - SINE_FRAC_BITS;
  localparam int SCALE_SHIFT = SINE_FRAC_BITS + AMP_FRAC_BITS;

  localparam logic [WORD_W-1:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
  localparam logic [WORD_W-1:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [WORD_W-1:0] LIMIT16 = 64'd32767;
  localparam logic [WORD_W-1:0] LIMIT32 = 64'd2147483647;

  localparam logic [AMP_W-1:0]     AMP_RESET = 17'd65536;
  localparam logic [FOLD_BITS-1:0] QUARTER   = {1'b1, {QUAD_BITS{1'b0}}};

  localparam logic FMT_16 = 1'b0;
  localparam logic FMT_32 = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TUNING    = 2'd0,
    REG_AMPLITUDE = 2'd1,
    REG_FORMAT    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MOP_ANGLE  = 3'd0,
    MOP_SQUARE = 3'd1,
    MOP_TERM   = 3'd2,
    MOP_AMP    = 3'd3,
    MOP_SCALE  = 3'd4
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_start;
    mul_op_t mul_op;
    logic    cap_angle;
    logic    cap_square;
    logic    div_start;
    logic    cap_term;
    logic    set_special;
    logic    out_write;
  } dp_cmd_t;

  typedef struct packed {
    logic special;
    logic mul_busy;
    logic mul_done;
    logic div_done;
    logic last_term;
    logic out_free;
  } dp_sts_t;

  // Divisor (2k)(2k+1) of the k-th series term.
  function automatic logic [DIV_W-1:0] term_divisor(input logic [TERM_CNT_W-1:0] k);
    logic [DIV_W-1:0] d;
    case (k)
      4'd1:    d = 9'd6;
      4'd2:    d = 9'd20;
      4'd3:    d = 9'd42;
      4'd4:    d = 9'd72;
      4'd5:    d = 9'd110;
      4'd6:    d = 9'd156;
      4'd7:    d = 9'd210;
      4'd8:    d = 9'd272;
      4'd9:    d = 9'd342;
      4'd10:   d = 9'd420;
      4'd11:   d = 9'd506;
      default: d = 9'd6;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ssg_in_if.sv =====
`default_nettype none
interface ssg_in_if;
  logic valid;
  logic ready;
  logic restart;
  logic block_end;

  modport source (output valid, output restart, output block_end, input ready);
  modport sink (input valid, input restart, input block_end, output ready);
endinterface
`default_nettype wire

// ===== sv/ssg_out_if.sv =====
`default_nettype none
interface ssg_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ssg_pkg::SAMPLE_W-1:0]     sample;
  logic                                    clipped;
  logic                                    block_last;

  modport source (output valid, output sample, output clipped, output block_last, input ready);
  modport sink (input valid, input sample, input clipped, input block_last, output ready);
endinterface
`default_nettype wire

// ===== sv/ssg_cfg_if.sv =====
`default_nettype none
interface ssg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ssg_pkg::CFG_INDEX_W-1:0]    index;
  logic [ssg_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/ssg_mul.sv =====
`default_nettype none
module ssg_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ssg_pkg::WORD_W-1:0]  a,
  input  logic [ssg_pkg::WORD_W-1:0]  b,
  output logic [ssg_pkg::PROD_W-1:0]  prod,
  output logic                        busy,
  output logic                        done
);

  localparam int MUL_STEPS = 4;

  logic [ssg_pkg::WORD_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [ssg_pkg::WORD_W-1:0] pp_r, pp_nxt;
  logic [ssg_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic [1:0]                 sh_r, sh_nxt;
  logic [2:0]                 step_r, step_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  logic [ssg_pkg::HALF_W-1:0] a_part, b_part;
  logic [ssg_pkg::WORD_W-1:0] pp_calc;
  logic [ssg_pkg::PROD_W-1:0] pp_al;

  // Partial products in the order a0*b0, a0*b1, a1*b0, a1*b1.
  assign a_part  = step_r[1] ? a_r[ssg_pkg::WORD_W-1:ssg_pkg::HALF_W] : a_r[ssg_pkg::HALF_W-1:0];
  assign b_part  = step_r[0] ? b_r[ssg_pkg::WORD_W-1:ssg_pkg::HALF_W] : b_r[ssg_pkg::HALF_W-1:0];
  assign pp_calc = a_part * b_part;

  always_comb begin
    case (sh_r)
      2'd0:    pp_al = {{ssg_pkg::WORD_W{1'b0}}, pp_r};
      2'd1:    pp_al = {{ssg_pkg::HALF_W{1'b0}}, pp_r, {ssg_pkg::HALF_W{1'b0}}};
      default: pp_al = {pp_r, {ssg_pkg::WORD_W{1'b0}}};
    endcase
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    pp_nxt   = pp_r;
    sh_nxt   = sh_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (step_r != 3'(MUL_STEPS)) begin
        pp_nxt = pp_calc;
        sh_nxt = 2'(step_r[0]) + 2'(step_r[1]);
      end
      if (step_r != 3'd0) begin
        acc_nxt = acc_r + pp_al;
      end
      step_nxt = step_r + 3'd1;
      if (step_r == 3'(MUL_STEPS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    pp_r  <= pp_nxt;
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
  end

  assign prod = acc_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== sv/ssg_div.sv =====
`default_nettype none
module ssg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ssg_pkg::WORD_W-1:0]  dividend,
  input  logic [ssg_pkg::DIV_W-1:0]   divisor,
  output logic [ssg_pkg::WORD_W-1:0]  quotient,
  output logic                        done
);

  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = ssg_pkg::WORD_W / DIV_STEPS;
  localparam int CNT_W      = $clog2(DIV_CYCLES);

  logic [ssg_pkg::WORD_W-1:0] dvd_r, dvd_nxt;
  logic [ssg_pkg::WORD_W-1:0] quot_r, quot_nxt;
  logic [ssg_pkg::DIV_W-1:0]  dsr_r, dsr_nxt;
  logic [ssg_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  logic [ssg_pkg::DIV_W-1:0]  rem_step;
  logic [DIV_STEPS-1:0]       qbits;

  // Four restoring steps per cycle; the remainder stays below the divisor.
  always_comb begin
    logic [ssg_pkg::DIV_W:0] t;
    rem_step = rem_r;
    qbits    = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {rem_step, dvd_r[ssg_pkg::WORD_W-1-i]};
      if (t >= {1'b0, dsr_r}) begin
        rem_step                 = ssg_pkg::DIV_W'(t - {1'b0, dsr_r});
        qbits[DIV_STEPS-1-i]     = 1'b1;
      end else begin
        rem_step                 = t[ssg_pkg::DIV_W-1:0];
      end
    end
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[ssg_pkg::WORD_W-DIV_STEPS-1:0], {DIV_STEPS{1'b0}}};
      quot_nxt = {quot_r[ssg_pkg::WORD_W-DIV_STEPS-1:0], qbits};
      rem_nxt  = rem_step;
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_CYCLES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    dsr_r  <= dsr_nxt;
    rem_r  <= rem_nxt;
  end

  assign quotient = quot_r;
  assign done     = done_r;

endmodule
`default_nettype wire

// ===== sv/ssg_datapath.sv =====
`default_nettype none
module ssg_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_restart,
  input  logic                                 in_block_end,
  input  logic                                 cfg_valid,
  input  logic [ssg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ssg_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [ssg_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                 out_clipped,
  output logic                                 out_block_last,
  input  ssg_pkg::dp_cmd_t                     cmd,
  output ssg_pkg::dp_sts_t                     sts
);

  localparam int PB = ssg_pkg::PHASE_BITS;
  localparam int W  = ssg_pkg::WORD_W;

  logic [ssg_pkg::TUNE_W-1:0]     tuning_word_r, tuning_word_nxt;
  logic [ssg_pkg::AMP_W-1:0]      amplitude_r, amplitude_nxt;
  logic                           sample_format_r, sample_format_nxt;
  logic [PB-1:0]                  phase_acc_r, phase_acc_nxt;
  logic [PB-1:0]                  work_phase_r, work_phase_nxt;
  logic                           block_r, block_nxt;
  logic [W-1:0]                   x_r, x_nxt, x2_r, x2_nxt;
  logic [W-1:0]                   term_r, term_nxt, sum_r, sum_nxt;
  logic [ssg_pkg::TERM_CNT_W-1:0] k_r, k_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ssg_pkg::SAMPLE_W-1:0]   sample_r, sample_nxt;
  logic                           clipped_r, clipped_nxt;
  logic                           last_r, last_nxt;

  logic [PB-1:0]                  start_phase;
  logic [PB+ssg_pkg::TUNE_W-1:0]  tune_wide;
  logic [1:0]                     quad;
  logic [ssg_pkg::FOLD_BITS-1:0]  fold;
  logic [W-1:0]                   angle_u;
  logic [W-1:0]                   limit;
  logic [W-1:0]                   mag, mag_sat;
  logic                           clip;
  logic [ssg_pkg::SAMPLE_W-1:0]   val;
  logic                           out_free;

  logic [W-1:0]                   mul_a, mul_b;
  logic [ssg_pkg::PROD_W-1:0]     prod;
  logic                           mul_busy, mul_done;
  logic [W-1:0]                   quot;
  logic                           div_done;

  ssg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .busy  (mul_busy),
    .done  (mul_done)
  );

  ssg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod[ssg_pkg::Q_BITS+W-1:ssg_pkg::Q_BITS]),
    .divisor  (ssg_pkg::term_divisor(k_r)),
    .quotient (quot),
    .done     (div_done)
  );

  assign start_phase = in_restart ? '0 : phase_acc_r;
  assign tune_wide   = {tuning_word_r, {PB{1'b0}}};

  // Fold the phase into the first quadrant; odd quadrants are mirrored.
  assign quad    = work_phase_r[PB-1:PB-2];
  assign fold    = quad[0] ? (ssg_pkg::QUARTER - {1'b0, work_phase_r[ssg_pkg::QUAD_BITS-1:0]})
                           : {1'b0, work_phase_r[ssg_pkg::QUAD_BITS-1:0]};
  assign angle_u = {2'b00, fold[ssg_pkg::QUAD_BITS-1:0], {(W - PB){1'b0}}};

  assign limit   = (sample_format_r == ssg_pkg::FMT_32) ? ssg_pkg::LIMIT32 : ssg_pkg::LIMIT16;
  assign mag     = prod[ssg_pkg::SCALE_SHIFT+W-1:ssg_pkg::SCALE_SHIFT];
  assign clip    = mag > limit;
  assign mag_sat = clip ? limit : mag;
  assign val     = quad[1] ? (ssg_pkg::SAMPLE_W'(0) - mag_sat[ssg_pkg::SAMPLE_W-1:0])
                           : mag_sat[ssg_pkg::SAMPLE_W-1:0];

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (cmd.mul_op)
      ssg_pkg::MOP_ANGLE: begin
        mul_a = angle_u;
        mul_b = ssg_pkg::PI_Q60;
      end
      ssg_pkg::MOP_SQUARE: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      ssg_pkg::MOP_TERM: begin
        mul_a = term_r;
        mul_b = x2_r;
      end
      ssg_pkg::MOP_AMP: begin
        mul_a = sum_r >> ssg_pkg::AMP_SHIFT;
        mul_b = W'(amplitude_r);
      end
      ssg_pkg::MOP_SCALE: begin
        mul_a = prod[W-1:0];
        mul_b = limit;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    tuning_word_nxt   = tuning_word_r;
    amplitude_nxt     = amplitude_r;
    sample_format_nxt = sample_format_r;
    if (cfg_valid) begin
      case (ssg_pkg::cfg_reg_t'(cfg_index))
        ssg_pkg::REG_TUNING:    tuning_word_nxt   = cfg_data[ssg_pkg::TUNE_W-1:0];
        ssg_pkg::REG_AMPLITUDE: amplitude_nxt     = cfg_data[ssg_pkg::AMP_W-1:0];
        ssg_pkg::REG_FORMAT:    sample_format_nxt = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    phase_acc_nxt  = phase_acc_r;
    work_phase_nxt = work_phase_r;
    block_nxt      = block_r;
    x_nxt          = x_r;
    x2_nxt         = x2_r;
    term_nxt       = term_r;
    sum_nxt        = sum_r;
    k_nxt          = k_r;
    if (cmd.load) begin
      work_phase_nxt = start_phase;
      phase_acc_nxt  = start_phase + tune_wide[PB+ssg_pkg::TUNE_W-1:ssg_pkg::TUNE_W];
      block_nxt      = in_block_end;
    end
    if (cmd.set_special) begin
      sum_nxt = fold[ssg_pkg::FOLD_BITS-1] ? ssg_pkg::ONE_Q60 : '0;
    end
    if (cmd.cap_angle) begin
      x_nxt    = prod[ssg_pkg::ANGLE_SHIFT+W-1:ssg_pkg::ANGLE_SHIFT];
      term_nxt = prod[ssg_pkg::ANGLE_SHIFT+W-1:ssg_pkg::ANGLE_SHIFT];
      sum_nxt  = prod[ssg_pkg::ANGLE_SHIFT+W-1:ssg_pkg::ANGLE_SHIFT];
    end
    if (cmd.cap_square) begin
      x2_nxt = prod[ssg_pkg::Q_BITS+W-1:ssg_pkg::Q_BITS];
      k_nxt  = ssg_pkg::TERM_CNT_W'(1);
    end
    if (cmd.cap_term) begin
      term_nxt = quot;
      sum_nxt  = k_r[0] ? (sum_r - quot) : (sum_r + quot);
      k_nxt    = k_r + ssg_pkg::TERM_CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    sample_nxt    = sample_r;
    clipped_nxt   = clipped_r;
    last_nxt      = last_r;
    if (cmd.out_write) begin
      out_valid_nxt = 1'b1;
      sample_nxt    = val;
      clipped_nxt   = clip;
      last_nxt      = block_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tuning_word_r   <= '0;
      amplitude_r     <= ssg_pkg::AMP_RESET;
      sample_format_r <= ssg_pkg::FMT_16;
      phase_acc_r     <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      tuning_word_r   <= tuning_word_nxt;
      amplitude_r     <= amplitude_nxt;
      sample_format_r <= sample_format_nxt;
      phase_acc_r     <= phase_acc_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_phase_r <= work_phase_nxt;
    block_r      <= block_nxt;
    x_r          <= x_nxt;
    x2_r         <= x2_nxt;
    term_r       <= term_nxt;
    sum_r        <= sum_nxt;
    k_r          <= k_nxt;
    sample_r     <= sample_nxt;
    clipped_r    <= clipped_nxt;
    last_r       <= last_nxt;
  end

  assign sts.special   = (fold == '0) || fold[ssg_pkg::FOLD_BITS-1];
  assign sts.mul_busy  = mul_busy;
  assign sts.mul_done  = mul_done;
  assign sts.div_done  = div_done;
  assign sts.last_term = k_r == ssg_pkg::TERM_CNT_W'(ssg_pkg::TERMS);
  assign sts.out_free  = out_free;

  assign out_valid      = out_valid_r;
  assign out_sample     = sample_r;
  assign out_clipped    = clipped_r;
  assign out_block_last = last_r;

endmodule
`default_nettype wire

// ===== sv/ssg_ctrl.sv =====
`default_nettype none
module ssg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output ssg_pkg::dp_cmd_t  cmd,
  input  ssg_pkg::dp_sts_t  sts
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'h0001,
    S_FOLD    = 13'h0002,
    S_ANGLE_W = 13'h0004,
    S_SQ      = 13'h0008,
    S_SQ_W    = 13'h0010,
    S_TMUL    = 13'h0020,
    S_TMUL_W  = 13'h0040,
    S_DIV_W   = 13'h0080,
    S_AMP     = 13'h0100,
    S_AMP_W   = 13'h0200,
    S_SCALE   = 13'h0400,
    S_SCALE_W = 13'h0800,
    S_DONE    = 13'h1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        if (sts.special) begin
          cmd.set_special = 1'b1;
          state_nxt       = S_AMP;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = ssg_pkg::MOP_ANGLE;
          state_nxt     = S_ANGLE_W;
        end
      end
      S_ANGLE_W: begin
        if (sts.mul_done) begin
          cmd.cap_angle = 1'b1;
          state_nxt     = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = ssg_pkg::MOP_SQUARE;
        state_nxt     = S_SQ_W;
      end
      S_SQ_W: begin
        if (sts.mul_done) begin
          cmd.cap_square = 1'b1;
          state_nxt      = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = ssg_pkg::MOP_TERM;
        state_nxt     = S_TMUL_W;
      end
      S_TMUL_W: begin
        if (sts.mul_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_W;
        end
      end
      S_DIV_W: begin
        if (sts.div_done) begin
          cmd.cap_term = 1'b1;
          state_nxt    = sts.last_term ? S_AMP : S_TMUL;
        end
      end
      S_AMP: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = ssg_pkg::MOP_AMP;
        state_nxt     = S_AMP_W;
      end
      S_AMP_W: begin
        if (sts.mul_done) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = ssg_pkg::MOP_SCALE;
        state_nxt     = S_SCALE_W;
      end
      S_SCALE_W: begin
        if (sts.mul_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_write = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !sts.mul_busy)
    else $error("multiplier started while busy");

  a_div_operand: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> sts.mul_done)
    else $error("divider started without a finished product");

  a_div_waited: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIV_W)
    else $error("divider finished outside its wait state");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_write |-> sts.out_free)
    else $error("output register overwritten before it was taken");

endmodule
`default_nettype wire

// ===== sv/sine_sample_generator.sv =====
`default_nettype none
// Channel   Direction  Payload                               Beat completes
// in_bus    sink       restart, block_end                    valid && ready
// out_bus   source     sample, clipped, block_last           valid && ready
// cfg_bus   sink       index, data (0 tuning, 1 gain, 2 fmt) valid && ready (always ready)
//
// A request is worked through the eleven series terms, each a four-pass product
// on the shared 32x32 multiplier and one radix-16 division. At the zero and
// quarter phase points the series is skipped and only the scaling steps remain.
// Reset is synchronous and active low; the phase returns to zero and the
// registers to their defaults. A result waits in the output register while
// the next request is accepted and worked on.
module sine_sample_generator (
  input  logic         clk,
  input  logic         rst_n,
  ssg_in_if.sink       in_bus,
  ssg_out_if.source    out_bus,
  ssg_cfg_if.sink      cfg_bus
);

  ssg_pkg::dp_cmd_t cmd;
  ssg_pkg::dp_sts_t sts;
  logic             in_ready;

  ssg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ssg_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_restart     (in_bus.restart),
    .in_block_end   (in_bus.block_end),
    .cfg_valid      (cfg_bus.valid),
    .cfg_index      (cfg_bus.index),
    .cfg_data       (cfg_bus.data),
    .out_ready      (out_bus.ready),
    .out_valid      (out_bus.valid),
    .out_sample     (out_bus.sample),
    .out_clipped    (out_bus.clipped),
    .out_block_last (out_bus.block_last),
    .cmd            (cmd),
    .sts            (sts)
  );

  assign in_bus.ready  = in_ready;
  assign cfg_bus.ready = 1'b1;

endmodule
`default_nettype wire
